@@ src/jpdch_pkg.sv @@
package jpdch_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned VEL_W   = 24;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned TQ_W    = 16;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned JOINT_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // datapath widths: gp*(pt-pm) is 17x33, gd*(vt-vm) is 17x25
  localparam int unsigned P1_W  = 50;
  localparam int unsigned P2_W  = 42;
  localparam int unsigned ACC_W = 52;
  localparam int unsigned DRV_W = ACC_W - 6;

  localparam logic [POS_W-1:0] POS_STOP_CODE = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_STOP_CODE = 24'd4096000;
  localparam logic [7:0]       MODE_ENABLED  = 8'h01;
  localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_COMMAND    = 2'd0,
    KIND_CONTROL    = 2'd1,
    KIND_HOLD_RESET = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_MODE    = 3'd0,
    REG_TIMEOUT_TICKS = 3'd1,
    REG_IDLE_GAIN_P   = 3'd2,
    REG_IDLE_GAIN_D   = 3'd3,
    REG_DRIVE_MIN     = 3'd4,
    REG_DRIVE_MAX     = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic [JOINT_W-1:0]       joint;
    logic                     last;
    logic [7:0]               motor_mode;
    logic signed [POS_W-1:0]  position;
    logic signed [VEL_W-1:0]  velocity;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_d;
    logic signed [TQ_W-1:0]   torque;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint_out;
    logic signed [POS_W-1:0]  drive;
    logic [GAIN_W-1:0]        gain_p_out;
    logic [GAIN_W-1:0]        gain_d_out;
    logic                     following_command;
    logic                     last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic signed [VEL_W-1:0]  velocity;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_d;
    logic signed [TQ_W-1:0]   torque;
  } entry_t;

  typedef struct packed {
    logic                     servo_mode;
    logic [AGE_W-1:0]         timeout_ticks;
    logic [GAIN_W-1:0]        idle_gain_p;
    logic [GAIN_W-1:0]        idle_gain_d;
    logic signed [POS_W-1:0]  drive_min;
    logic signed [POS_W-1:0]  drive_max;
  } cfg_t;

  // control-element sideband that travels beside the RAM read
  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic                     last;
    logic                     follow;
    logic signed [POS_W-1:0]  meas_pos;
    logic signed [VEL_W-1:0]  meas_vel;
  } req_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic                     last;
    logic                     follow;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_d;
  } meta_t;

endpackage

@@ src/jpdch_ram.sv @@
module jpdch_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ src/jpdch_cfg.sv @@
module jpdch_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jpdch_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  output jpdch_pkg::cfg_t                    cfg_o
);

  jpdch_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jpdch_pkg::REG_SERVO_MODE:    cfg_d.servo_mode    = cfg_data_i[0];
        jpdch_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[15:0];
        jpdch_pkg::REG_IDLE_GAIN_P:   cfg_d.idle_gain_p   = cfg_data_i[15:0];
        jpdch_pkg::REG_IDLE_GAIN_D:   cfg_d.idle_gain_d   = cfg_data_i[15:0];
        jpdch_pkg::REG_DRIVE_MIN:     cfg_d.drive_min     = $signed(cfg_data_i);
        jpdch_pkg::REG_DRIVE_MAX:     cfg_d.drive_max     = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_mode    <= 1'b0;
      cfg_q.timeout_ticks <= 16'd125;
      cfg_q.idle_gain_p   <= 16'd5120;
      cfg_q.idle_gain_d   <= 16'd384;
      cfg_q.drive_min     <= -32'sd2949120;
      cfg_q.drive_max     <= 32'sd2949120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/jpdch_pd_pipe.sv @@
module jpdch_pd_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jpdch_pkg::cfg_t       cfg_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  jpdch_pkg::req_t       req_i,
  input  jpdch_pkg::entry_t     ent_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output jpdch_pkg::out_item_t  out_data_o
);

  localparam int unsigned P1_W  = jpdch_pkg::P1_W;
  localparam int unsigned P2_W  = jpdch_pkg::P2_W;
  localparam int unsigned ACC_W = jpdch_pkg::ACC_W;
  localparam int unsigned DRV_W = jpdch_pkg::DRV_W;

  logic v2_q, v3_q, vo_q;
  logic rdy2, rdy3, rdyo;

  assign rdyo        = !vo_q || !out_stall_i;
  assign rdy3        = !v3_q || rdyo;
  assign rdy2        = !v2_q || rdy3;
  assign req_ready_o = rdy2;

  // stage 2: differences and products
  logic signed [32:0]     dp;
  logic signed [24:0]     dv;
  logic signed [P1_W-1:0] p1_d, p1_q;
  logic signed [P2_W-1:0] p2_d, p2_q;
  logic signed [15:0]     tq_q;
  logic signed [31:0]     tgt_q;
  jpdch_pkg::meta_t       m2_q, m2_d;

  assign dp   = $signed({ent_i.position[31], ent_i.position})
              - $signed({req_i.meas_pos[31], req_i.meas_pos});
  assign dv   = $signed({ent_i.velocity[23], ent_i.velocity})
              - $signed({req_i.meas_vel[23], req_i.meas_vel});
  assign p1_d = $signed({1'b0, ent_i.gain_p}) * dp;
  assign p2_d = $signed({1'b0, ent_i.gain_d}) * dv;

  always_comb begin
    m2_d.joint  = req_i.joint;
    m2_d.last   = req_i.last;
    m2_d.follow = req_i.follow;
    m2_d.gain_p = ent_i.gain_p;
    m2_d.gain_d = ent_i.gain_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && req_valid_i) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      tq_q  <= ent_i.torque;
      tgt_q <= ent_i.position;
      m2_q  <= m2_d;
    end
  end

  // stage 3: sum at 22 fractional bits, round to 16
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        ff_term;
  logic signed [DRV_W-1:0] val_d, val_q;
  jpdch_pkg::meta_t        m3_q;

  assign ff_term = m2_q.follow ? {{(ACC_W-30){tq_q[15]}}, tq_q, 14'b0} : '0;
  assign acc = {{(ACC_W-P1_W){p1_q[P1_W-1]}}, p1_q}
             + {{(ACC_W-P2_W-8){p2_q[P2_W-1]}}, p2_q, 8'b0}
             + ff_term
             + ACC_W'(32);

  always_comb begin
    if (cfg_i.servo_mode) begin
      val_d = $signed({{(DRV_W-32){tgt_q[31]}}, tgt_q});
    end else begin
      val_d = $signed(acc[ACC_W-1:6]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      val_q <= val_d;
      m3_q  <= m2_q;
    end
  end

  // output stage: clamp, drive_max wins on crossed limits
  logic signed [DRV_W-1:0] lo, hi, lo_clamped, fin;
  jpdch_pkg::out_item_t    out_q, out_d;

  assign lo = $signed({{(DRV_W-32){cfg_i.drive_min[31]}}, cfg_i.drive_min});
  assign hi = $signed({{(DRV_W-32){cfg_i.drive_max[31]}}, cfg_i.drive_max});
  assign lo_clamped = (val_q < lo) ? lo : val_q;
  assign fin        = (lo_clamped > hi) ? hi : lo_clamped;

  always_comb begin
    out_d.joint_out         = m3_q.joint;
    out_d.drive             = fin[31:0];
    out_d.gain_p_out        = m3_q.gain_p;
    out_d.gain_d_out        = m3_q.gain_d;
    out_d.following_command = m3_q.follow;
    out_d.last_out          = m3_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= req_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

@@ src/joint_pd_command_hold.sv @@
// Per-joint PD drive with command hold and watchdog. One element is taken per
// cycle while in_stall_o is low, of any kind, back to back. Command and
// hold-reset elements for an in-range joint write the 2*JOINTS-entry bank RAM
// at acceptance and give no result; a control element for an in-range joint
// reads its held entry from the RAM and presents one drive transaction through
// the RAM read, multiply, sum/round and clamp registers. The pipeline only
// holds when its output transaction is stalled and every stage behind it is
// full. Bank entries are undefined until written by a hold reset or a command;
// there is no clearing pass. Configuration writes are always ready and should
// only be issued while the block is idle.
module joint_pd_command_hold #(
  parameter int unsigned JOINTS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  jpdch_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output jpdch_pkg::out_item_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jpdch_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int unsigned DEPTH  = 2 * JOINTS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ENT_W  = $bits(jpdch_pkg::entry_t);

  jpdch_pkg::cfg_t cfg;

  jpdch_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // control state
  logic                          hold_q, hold_d;
  logic                          active_q, active_d;
  logic                          any_q, any_d;
  logic [jpdch_pkg::AGE_W-1:0]   age_q, age_d;
  logic                          v1_q, v1_d;
  jpdch_pkg::req_t               req_q, req_d;

  logic ready1, pipe_ready, accept, joint_ok, act, msg_any, follow;
  logic [ADDR_W-1:0] hold_addr, spare_addr;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr;
  jpdch_pkg::entry_t wr_ent, rd_ent;
  logic [ENT_W-1:0]  rd_raw;

  assign ready1     = !v1_q || pipe_ready;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;
  assign joint_ok   = 32'(in_data_i.joint) < JOINTS;
  assign follow     = active_q && (age_q <= cfg.timeout_ticks);

  assign hold_addr  = hold_q ? ADDR_W'(JOINTS) + ADDR_W'(in_data_i.joint)
                             : ADDR_W'(in_data_i.joint);
  assign spare_addr = hold_q ? ADDR_W'(in_data_i.joint)
                             : ADDR_W'(JOINTS) + ADDR_W'(in_data_i.joint);

  assign act = (in_data_i.motor_mode == jpdch_pkg::MODE_ENABLED)
            && (in_data_i.position != jpdch_pkg::POS_STOP_CODE)
            && (in_data_i.velocity != jpdch_pkg::VEL_STOP_CODE)
            && !(in_data_i.gain_p == '0 && in_data_i.gain_d == '0
                 && in_data_i.torque == '0);
  assign msg_any = any_q || (joint_ok && act);

  always_comb begin
    hold_d   = hold_q;
    active_d = active_q;
    any_d    = any_q;
    age_d    = age_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = hold_addr;
    wr_ent.position = in_data_i.position;
    wr_ent.velocity = in_data_i.velocity;
    wr_ent.gain_p   = in_data_i.gain_p;
    wr_ent.gain_d   = in_data_i.gain_d;
    wr_ent.torque   = in_data_i.torque;
    req_d.joint    = in_data_i.joint;
    req_d.last     = in_data_i.last;
    req_d.follow   = follow;
    req_d.meas_pos = in_data_i.position;
    req_d.meas_vel = in_data_i.velocity;
    if (accept) begin
      unique case (in_data_i.kind)
        jpdch_pkg::KIND_COMMAND: begin
          wr_en   = joint_ok;
          wr_addr = spare_addr;
          if (in_data_i.last) begin
            active_d = msg_any;
            if (msg_any) hold_d = !hold_q;
            age_d = '0;
            any_d = 1'b0;
          end else begin
            any_d = msg_any;
          end
        end
        jpdch_pkg::KIND_CONTROL: begin
          rd_en = joint_ok;
          if (in_data_i.last && age_q != jpdch_pkg::AGE_MAX) begin
            age_d = age_q + 1'b1;
          end
        end
        jpdch_pkg::KIND_HOLD_RESET: begin
          wr_en           = joint_ok;
          wr_ent.velocity = '0;
          wr_ent.gain_p   = cfg.idle_gain_p;
          wr_ent.gain_d   = cfg.idle_gain_d;
          wr_ent.torque   = '0;
          active_d        = 1'b0;
        end
        default: ;
      endcase
    end
    v1_d = ready1 ? rd_en : v1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= 1'b0;
      active_q <= 1'b0;
      any_q    <= 1'b0;
      age_q    <= '0;
      v1_q     <= 1'b0;
    end else begin
      hold_q   <= hold_d;
      active_q <= active_d;
      any_q    <= any_d;
      age_q    <= age_d;
      v1_q     <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      req_q <= req_d;
    end
  end

  jpdch_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_bank (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_ent),
    .rd_en_i   (rd_en),
    .rd_addr_i (hold_addr),
    .rd_data_o (rd_raw)
  );

  assign rd_ent = rd_raw;

  jpdch_pd_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (v1_q),
    .req_ready_o (pipe_ready),
    .req_i       (req_q),
    .ent_i       (rd_ent),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/tb_joint_pd_command_hold.sv @@
`timescale 1ns / 100ps

module tb_joint_pd_command_hold;

  localparam int JOINTS = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  jpdch_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  jpdch_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jpdch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // joint model: config, two banks, hold selection, watchdog age
  jpdch_pkg::cfg_t cfg_model;
  jpdch_pkg::entry_t bank [2*JOINTS];
  bit [2*JOINTS-1:0] written;
  bit hold_sel;
  bit cmd_active;
  bit msg_active;
  logic [jpdch_pkg::AGE_W-1:0] cmd_age;
  jpdch_pkg::out_item_t expected_drives [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit sender_idle = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;
  jpdch_pkg::out_item_t want;

  joint_pd_command_hold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic void reset_model();
    cfg_model = '{servo_mode: 1'b0, timeout_ticks: 16'd125, idle_gain_p: 16'd5120,
                  idle_gain_d: 16'd384, drive_min: -32'sd2949120, drive_max: 32'sd2949120};
    written = '0;
    hold_sel = 1'b0;
    cmd_active = 1'b0;
    msg_active = 1'b0;
    cmd_age = '0;
  endfunction

  function automatic void apply_reg(input jpdch_pkg::reg_e idx, input logic [31:0] v);
    case (idx)
      jpdch_pkg::REG_SERVO_MODE:    cfg_model.servo_mode = v[0];
      jpdch_pkg::REG_TIMEOUT_TICKS: cfg_model.timeout_ticks = v[jpdch_pkg::AGE_W-1:0];
      jpdch_pkg::REG_IDLE_GAIN_P:   cfg_model.idle_gain_p = v[jpdch_pkg::GAIN_W-1:0];
      jpdch_pkg::REG_IDLE_GAIN_D:   cfg_model.idle_gain_d = v[jpdch_pkg::GAIN_W-1:0];
      jpdch_pkg::REG_DRIVE_MIN:     cfg_model.drive_min = v;
      jpdch_pkg::REG_DRIVE_MAX:     cfg_model.drive_max = v;
      default: ;
    endcase
  endfunction

  // upper limit applied last, so it wins when the limits cross
  function automatic logic [31:0] clamp_drive(input longint v);
    longint lo, hi;
    lo = cfg_model.drive_min;
    hi = cfg_model.drive_max;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[31:0];
  endfunction

  function automatic void apply_element(input jpdch_pkg::in_item_t it);
    int k;
    bit in_range, follow, active;
    longint gp, gd, dp, dv, tq, acc;
    jpdch_pkg::entry_t e;
    jpdch_pkg::out_item_t r;
    in_range = it.joint < JOINTS;
    case (it.kind)
      jpdch_pkg::KIND_COMMAND: begin
        if (in_range) begin
          k = (hold_sel ? 0 : JOINTS) + it.joint;
          bank[k] = '{it.position, it.velocity, it.gain_p, it.gain_d, it.torque};
          written[k] = 1'b1;
          active = it.motor_mode == jpdch_pkg::MODE_ENABLED &&
                   it.position != jpdch_pkg::POS_STOP_CODE &&
                   it.velocity != jpdch_pkg::VEL_STOP_CODE &&
                   !(it.gain_p == 0 && it.gain_d == 0 && it.torque == 0);
          if (active) msg_active = 1'b1;
        end
        if (it.last) begin
          cmd_active = msg_active;
          if (msg_active) hold_sel = ~hold_sel;
          cmd_age = '0;
          msg_active = 1'b0;
        end
      end
      jpdch_pkg::KIND_CONTROL: begin
        if (in_range) begin
          k = (hold_sel ? JOINTS : 0) + it.joint;
          e = bank[k];
          follow = cmd_active && cmd_age <= cfg_model.timeout_ticks;
          if (cfg_model.servo_mode) begin
            acc = e.position;
          end else begin
            gp = e.gain_p;
            gd = e.gain_d;
            tq = e.torque;
            dp = longint'(e.position) - longint'(it.position);
            dv = longint'(e.velocity) - longint'(it.velocity);
            // sum at 22 fractional bits, round half up to Q16.16
            acc = gp * dp + gd * dv * 256 + (follow ? tq * 16384 : 64'sd0);
            acc = (acc + 32) >>> 6;
          end
          r.joint_out = it.joint;
          r.drive = clamp_drive(acc);
          r.gain_p_out = e.gain_p;
          r.gain_d_out = e.gain_d;
          r.following_command = follow;
          r.last_out = it.last;
          expected_drives.push_back(r);
        end
        if (it.last && cmd_age != jpdch_pkg::AGE_MAX) cmd_age = cmd_age + 1'b1;
      end
      jpdch_pkg::KIND_HOLD_RESET: begin
        if (in_range) begin
          k = (hold_sel ? JOINTS : 0) + it.joint;
          bank[k] = '{it.position, '0, cfg_model.idle_gain_p, cfg_model.idle_gain_d, '0};
          written[k] = 1'b1;
        end
        cmd_active = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic jpdch_pkg::in_item_t element(input logic [1:0] kind, input int joint,
                                                  input bit last, input logic [7:0] mode,
                                                  input logic [31:0] pos,
                                                  input logic [23:0] vel,
                                                  input logic [15:0] gp,
                                                  input logic [15:0] gd,
                                                  input logic [15:0] tq);
    jpdch_pkg::in_item_t it;
    it.kind = kind;
    it.joint = joint[jpdch_pkg::JOINT_W-1:0];
    it.last = last;
    it.motor_mode = mode;
    it.position = pos;
    it.velocity = vel;
    it.gain_p = gp;
    it.gain_d = gd;
    it.torque = tq;
    return it;
  endfunction

  function automatic logic [31:0] rand_position();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFE;
      default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [23:0] rand_velocity();
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'h80_0000;
      2: return 24'h7F_FFFF;
      default: return 24'($urandom_range(0, 32'h3FFF) - 32'h2000);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h1FFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_torque();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 16'h0FFF) - 16'h0800);
    endcase
  endfunction

  // mostly active content, now and then one of the inactive markers
  function automatic jpdch_pkg::in_item_t rand_command(input int joint, input bit last);
    jpdch_pkg::in_item_t it;
    it = element(jpdch_pkg::KIND_COMMAND, joint, last, jpdch_pkg::MODE_ENABLED,
                 rand_position(), rand_velocity(), rand_gain(), rand_gain(), rand_torque());
    case ($urandom_range(0, 15))
      0: it.motor_mode = 8'($urandom);
      1: it.position = jpdch_pkg::POS_STOP_CODE;
      2: it.velocity = jpdch_pkg::VEL_STOP_CODE;
      3: begin
        it.gain_p = '0;
        it.gain_d = '0;
        it.torque = '0;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send(input jpdch_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = sender_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    apply_element(it);
    if (it.kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic control(input int joint, input bit last, input logic [31:0] pos,
                         input logic [23:0] vel);
    send(element(jpdch_pkg::KIND_CONTROL, joint, last, 8'h00, pos, vel, 16'h0, 16'h0,
                 16'h0));
  endtask

  task automatic hold_reset(input int joint, input logic [31:0] pos);
    send(element(jpdch_pkg::KIND_HOLD_RESET, joint, 1'b0, 8'h00, pos, 24'h0, 16'h0, 16'h0,
                 16'h0));
  endtask

  task automatic write_reg(input jpdch_pkg::reg_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
    @(posedge clk_i);
  endtask

  // wait for every expected drive plus pipeline depth before touching config
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_hold_reset();
    stall_mode = STALL_NONE;
    sender_idle = 1'b0;
    send(element(jpdch_pkg::KIND_HOLD_RESET, 0, 1'b1, 8'hFF, 32'h8000_0000, 24'h7F_FFFF,
                 16'hFFFF, 16'hFFFF, 16'h7FFF));
    hold_reset(1, 32'h7FFF_FFFF);
    hold_reset(2, 32'h0000_0000);
    hold_reset(3, 32'h0001_8000);
    hold_reset(13, 32'h0000_1000);
    control(0, 1'b0, 32'h7FFF_FFFF, 24'h80_0000);
    control(1, 1'b0, 32'h8000_0000, 24'h7F_FFFF);
    control(2, 1'b0, 32'h0, 24'h0);
    control(3, 1'b1, 32'h0001_0000, 24'd100);
    control(12, 1'b0, 32'h0, 24'h0);
    control(15, 1'b1, 32'h0, 24'h0);
  endtask

  task automatic test_command_check();
    stall_mode = STALL_LIGHT;
    // stop position, then a disabled mode: message stays inactive
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED,
                 jpdch_pkg::POS_STOP_CODE, 24'h10, 16'd100, 16'd10, 16'd5));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b1, 8'h02, 32'h100, 24'h10, 16'd100, 16'd10,
                 16'd5));
    control(0, 1'b1, 32'h0, 24'h0);
    // zero gains and torque, then stop velocity
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h100, 24'h10,
                 16'h0, 16'h0, 16'h0));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b1, jpdch_pkg::MODE_ENABLED, 32'h100,
                 jpdch_pkg::VEL_STOP_CODE, 16'd100, 16'd10, 16'd5));
    // gains at both extremes, torque at both extremes, out-of-range joint inside
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h0001_0000,
                 24'h0, 16'h0, 16'h0, 16'h8000));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h8000_0000,
                 24'h80_0000, 16'hFFFF, 16'hFFFF, 16'h7FFF));
    send(element(jpdch_pkg::KIND_COMMAND, 14, 1'b1, 8'h00, 32'h0, 24'h0, 16'h0, 16'h0,
                 16'h0));
    control(0, 1'b0, 32'h0000_F000, 24'h0);
    control(1, 1'b1, 32'h7FFF_FFFF, 24'h7F_FFFF);
    // message made of an ignored joint only: inactive, bank kept
    send(element(jpdch_pkg::KIND_COMMAND, 14, 1'b1, jpdch_pkg::MODE_ENABLED, 32'h100,
                 24'h10, 16'd100, 16'd10, 16'd5));
    control(1, 1'b1, 32'h8000_0000, 24'h0);
    send(element(KIND_UNUSED, 15, 1'b1, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_command_timeout();
    settle();
    stall_mode = STALL_HEAVY;
    sender_idle = 1'b1;
    write_reg(jpdch_pkg::REG_TIMEOUT_TICKS, 32'd2);
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h0000_4000,
                 24'h40, 16'd2000, 16'd100, 16'd256));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b1, jpdch_pkg::MODE_ENABLED, 32'hFFFF_C000,
                 24'hFF_FFC0, 16'd900, 16'd50, 16'hFF00));
    for (int t = 0; t < 5; t++) begin
      control(0, 1'b0, 32'h0000_3000, 24'h20);
      control(3, 1'b1, 32'h0001_7000, 24'h0);
    end
    hold_reset(0, 32'h0000_2000);
    control(0, 1'b1, 32'h0, 24'h0);
    settle();
    write_reg(jpdch_pkg::REG_TIMEOUT_TICKS, 32'd0);
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h0000_1000,
                 24'h0, 16'd64, 16'd64, 16'd512));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b1, jpdch_pkg::MODE_ENABLED, 32'h0000_2000,
                 24'h0, 16'd64, 16'd64, 16'd512));
    control(0, 1'b1, 32'h0, 24'h0);
    control(1, 1'b1, 32'h0, 24'h0);
  endtask

  task automatic test_servo_and_clamp();
    settle();
    stall_mode = STALL_LIGHT;
    sender_idle = 1'b0;
    write_reg(jpdch_pkg::REG_IDLE_GAIN_P, 32'hFFFF);
    write_reg(jpdch_pkg::REG_IDLE_GAIN_D, 32'h0);
    write_reg(jpdch_pkg::REG_SERVO_MODE, 32'd1);
    write_reg(jpdch_pkg::REG_DRIVE_MIN, 32'h8000_0000);
    write_reg(jpdch_pkg::REG_DRIVE_MAX, 32'h7FFF_FFFF);
    hold_reset(2, 32'h1234_5678);
    control(2, 1'b0, 32'h0, 24'h0);
    control(0, 1'b1, 32'h0, 24'h0);
    settle();
    // crossed limits
    write_reg(jpdch_pkg::REG_DRIVE_MIN, 32'd100);
    write_reg(jpdch_pkg::REG_DRIVE_MAX, 32'hFFFF_FF9C);
    control(2, 1'b1, 32'h0, 24'h0);
    control(1, 1'b1, 32'h0, 24'h0);
    settle();
    write_reg(jpdch_pkg::REG_SERVO_MODE, 32'd0);
    write_reg(jpdch_pkg::REG_IDLE_GAIN_P, 32'h0);
    write_reg(jpdch_pkg::REG_IDLE_GAIN_D, 32'hFFFF);
    write_reg(jpdch_pkg::REG_DRIVE_MIN, 32'h8000_0000);
    write_reg(jpdch_pkg::REG_DRIVE_MAX, 32'h7FFF_FFFF);
    hold_reset(3, 32'h0);
    control(3, 1'b0, 32'h8000_0000, 24'h7F_FFFF);
    control(3, 1'b0, 32'h0, 24'h80_0000);
    control(2, 1'b1, 32'h1234_5678, 24'h0);
  endtask

  // age walks across the timeout edge, then the widest timeout follows again
  task automatic test_age_limit();
    settle();
    stall_mode = STALL_NONE;
    sender_idle = 1'b0;
    write_reg(jpdch_pkg::REG_TIMEOUT_TICKS, 32'd3);
    send(element(jpdch_pkg::KIND_COMMAND, 0, 1'b0, jpdch_pkg::MODE_ENABLED, 32'h0000_8000,
                 24'h0, 16'd300, 16'd20, 16'd128));
    send(element(jpdch_pkg::KIND_COMMAND, 1, 1'b1, jpdch_pkg::MODE_ENABLED, 32'h0, 24'h0,
                 16'd300, 16'd20, 16'd128));
    for (int t = 0; t < 6; t++) control(0, 1'b1, 32'h0, 24'h0);
    // ticks closed by an ignored joint only move the age
    control(15, 1'b1, 32'h0, 24'h0);
    control(1, 1'b1, 32'h0, 24'h0);
    settle();
    write_reg(jpdch_pkg::REG_TIMEOUT_TICKS, 32'd65535);
    control(0, 1'b1, 32'h0, 24'h0);
    control(1, 1'b1, 32'h0, 24'h0);
  endtask

  task automatic test_random_traffic();
    int target, r, n, t, swap_idx, base, j, k;
    int order [JOINTS];
    int avail [$];
    logic [31:0] lo, hi, pos;
    logic [23:0] vel;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      sender_idle = phase == 1 || phase == 3;
      stall_mode = phase == 2 ? STALL_LIGHT : (phase == 3 ? STALL_HEAVY : STALL_NONE);
      write_reg(jpdch_pkg::REG_SERVO_MODE, 32'($urandom_range(0, 3) == 0));
      write_reg(jpdch_pkg::REG_TIMEOUT_TICKS,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 12));
      write_reg(jpdch_pkg::REG_IDLE_GAIN_P, 32'(rand_gain()));
      write_reg(jpdch_pkg::REG_IDLE_GAIN_D, 32'(rand_gain()));
      case ($urandom_range(0, 3))
        0: begin
          lo = -32'sd2949120;
          hi = 32'sd2949120;
        end
        1: begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
        end
        2: begin
          lo = $urandom;
          hi = $urandom;
        end
        default: begin
          hi = $urandom_range(0, 32'h10_0000);
          lo = -hi;
        end
      endcase
      write_reg(jpdch_pkg::REG_DRIVE_MIN, lo);
      write_reg(jpdch_pkg::REG_DRIVE_MAX, hi);
      target = items_sent + 170;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          for (int i = 0; i < JOINTS; i++) order[i] = i;
          for (int i = JOINTS - 1; i > 0; i--) begin
            swap_idx = $urandom_range(0, i);
            t = order[i];
            order[i] = order[swap_idx];
            order[swap_idx] = t;
          end
          n = $urandom_range(0, 2) == 0 ? JOINTS : $urandom_range(1, JOINTS);
          t = $urandom_range(0, 9);
          // t: 0 leaves the message open, 1 closes it with an ignored joint
          for (int i = 0; i < n; i++) send(rand_command(order[i], t > 1 && i == n - 1));
          if (t == 1) send(rand_command($urandom_range(JOINTS, 15), 1'b1));
        end else if (r < 90) begin
          base = hold_sel ? JOINTS : 0;
          avail.delete();
          for (int i = 0; i < JOINTS; i++) if (written[base + i]) avail.push_back(i);
          n = avail.size() == 0 ? 0 : $urandom_range(1, avail.size());
          for (int i = 0; i < n; i++) begin
            j = avail[$urandom_range(0, avail.size() - 1)];
            k = base + j;
            pos = $urandom_range(0, 2) == 0 ? rand_position()
                                            : bank[k].position + $urandom_range(0, 32'hFFF)
                                              - 32'h800;
            vel = $urandom_range(0, 2) == 0 ? rand_velocity()
                                            : 24'(bank[k].velocity + $urandom_range(0, 32'hFF)
                                                  - 32'h80);
            send(element(jpdch_pkg::KIND_CONTROL, j, i == n - 1 && $urandom_range(0, 9) != 0,
                         8'($urandom), pos, vel, 16'($urandom), 16'($urandom),
                         16'($urandom)));
          end
          if (n == 0 || $urandom_range(0, 9) == 0)
            send(element(jpdch_pkg::KIND_CONTROL, $urandom_range(JOINTS, 15), 1'b1,
                         8'($urandom), $urandom, 24'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom)));
        end else if (r < 94) begin
          send(element(jpdch_pkg::KIND_HOLD_RESET, $urandom_range(0, 15),
                       1'($urandom_range(0, 1)), 8'($urandom), rand_position(),
                       24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
        end else begin
          send(element(KIND_UNUSED, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                       8'($urandom), $urandom, 24'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom)));
        end
      end
    end
  endtask

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        note_mismatch($sformatf("unexpected drive transaction: joint %0d drive %0d",
                                out_data.joint_out, out_data.drive));
      end else begin
        want = expected_drives.pop_front();
        if (want.joint_out !== out_data.joint_out || want.drive !== out_data.drive ||
            want.gain_p_out !== out_data.gain_p_out ||
            want.gain_d_out !== out_data.gain_d_out ||
            want.following_command !== out_data.following_command ||
            want.last_out !== out_data.last_out) begin
          note_mismatch($sformatf({"drive mismatch (exp/got): joint %0d/%0d drive %0d/%0d",
                                   " gp %0d/%0d gd %0d/%0d follow %0b/%0b last %0b/%0b"},
                                  want.joint_out, out_data.joint_out, want.drive,
                                  out_data.drive, want.gain_p_out, out_data.gain_p_out,
                                  want.gain_d_out, out_data.gain_d_out,
                                  want.following_command, out_data.following_command,
                                  want.last_out, out_data.last_out));
        end
      end
    end
  end

  // receiver back-pressure pattern
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        STALL_LIGHT: begin
          out_stall <= $urandom_range(0, 3) == 0;
          stall_left <= $urandom_range(0, 3);
        end
        STALL_HEAVY: begin
          out_stall <= $urandom_range(0, 2) != 0;
          stall_left <= $urandom_range(0, 10);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // no transaction on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hold_reset();
    test_command_check();
    test_command_timeout();
    test_servo_and_clamp();
    test_age_limit();
    test_random_traffic();
    settle();
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
